### rtl/pfla_pkg.sv
`timescale 1ns / 1ps
package pfla_pkg;

    localparam int unsigned POOL_BYTES_DEF    = 2048 * 1024;
    localparam int unsigned MAX_SEGMENTS_DEF  = 64;
    localparam int unsigned GRANULE_BYTES_DEF = 32;
    localparam int unsigned HEADER_BYTES      = 4;

    localparam int unsigned OPC_W  = 2;
    localparam int unsigned REQ_W  = 22;
    localparam int unsigned ADDR_W = 21;
    localparam int unsigned SIZE_W = 22;
    localparam int unsigned STAT_W = 2;

    localparam logic [OPC_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPC_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OPC_W-1:0] OP_DEFRAG = 2'd2;
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
        logic [SIZE_W-1:0] release_size;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] grant_address;
        logic [SIZE_W-1:0] grant_size;
        logic [SIZE_W-1:0] free_bytes;
    } t_result;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_AS_RD,
        S_AS_CMP,
        S_FS_RD,
        S_FS_CMP,
        S_DI_RD,
        S_DI_GET,
        S_DJ_RD,
        S_DJ_CMP,
        S_RM_RD,
        S_RM_WR,
        S_IN_RD,
        S_IN_WR,
        S_DONE
    } t_state;

endpackage

### rtl/pfla_ram.sv
`timescale 1ns / 1ps
module pfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/pool_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Best-fit pool allocator over a segment table held in a dual-port RAM. One command is
// taken when start is high and busy low; its result appears on o_result for exactly one
// cycle with o_done high and cannot be held off. After reset busy stays high for one cycle
// while the table's first entry is written. Every table read is registered in the RAM, so
// each entry scanned takes a read state and then a compare state: allocate and free scan the
// table entry by entry, then shift entries one at a time when an entry is removed or
// inserted; defragment rescans the table from the top after each merge.
module pool_free_list_allocator_core #(
    parameter int unsigned POOL_BYTES    = pfla_pkg::POOL_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS  = pfla_pkg::MAX_SEGMENTS_DEF,
    parameter int unsigned GRANULE_BYTES = pfla_pkg::GRANULE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pfla_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output pfla_pkg::t_result o_result
);

    localparam int unsigned LG  = $clog2(GRANULE_BYTES);
    localparam int unsigned PG  = POOL_BYTES / GRANULE_BYTES;
    localparam int unsigned GW  = $clog2(PG + 1);
    localparam int unsigned BW  = $clog2(PG);
    localparam int unsigned EW  = BW + GW;
    localparam int unsigned IW  = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned FTW = $clog2(POOL_BYTES + 1);
    localparam int unsigned SUMW = pfla_pkg::REQ_W + 1;
    localparam int unsigned NW  = SUMW - LG;
    localparam int unsigned SW  = pfla_pkg::SIZE_W - LG;
    localparam int unsigned XW0 = (GW + 1 > NW) ? GW + 1 : NW;
    localparam int unsigned XW  = ((XW0 > SW) ? XW0 : SW) + 1;
    localparam int unsigned TW  = (FTW > SUMW ? FTW : SUMW) + 1;

    pfla_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_i, n_i, r_k, n_k, r_count, n_count, r_best, n_best;
    logic [FTW-1:0]  r_free, n_free;
    logic [pfla_pkg::OPC_W-1:0] r_op, n_op;
    logic [NW-1:0]   r_need, n_need;
    logic [BW-1:0]   r_g, n_g;
    logic [SW-1:0]   r_n, n_n;
    logic            r_have, n_have;
    logic [GW-1:0]   r_bestg, n_bestg;
    logic [BW-1:0]   r_bestbase, n_bestbase;
    logic [BW-1:0]   r_curbase, n_curbase;
    logic [GW-1:0]   r_curg, n_curg;
    logic [pfla_pkg::STAT_W-1:0] r_status, n_status;
    logic [pfla_pkg::ADDR_W-1:0] r_gaddr, n_gaddr;
    logic [pfla_pkg::SIZE_W-1:0] r_gsize, n_gsize;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [BW-1:0] rd_base;
    logic [GW-1:0] rd_gran;

    logic [SUMW-1:0] req_sum;
    logic [SUMW-1:0] bytes;
    logic [TW-1:0]   free_plus_t;
    logic [FTW-1:0]  free_plus, free_minus;
    logic [GW-1:0]   n_clip;

    pfla_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_base = ram_rdata[GW +: BW];
    assign rd_gran = ram_rdata[GW-1:0];

    assign req_sum = SUMW'(i_cmd.request_bytes) + SUMW'(pfla_pkg::HEADER_BYTES)
                     + SUMW'(GRANULE_BYTES - 1);
    assign bytes   = SUMW'(r_need) << LG;

    // free_total update, saturating both ways
    assign free_plus_t = TW'(r_free) + (TW'(r_n) << LG);
    assign free_plus   = (free_plus_t > TW'(POOL_BYTES)) ? FTW'(POOL_BYTES)
                                                         : FTW'(free_plus_t);
    assign free_minus  = (TW'(r_free) > TW'(bytes)) ? FTW'(TW'(r_free) - TW'(bytes))
                                                    : '0;
    assign n_clip = (XW'(r_n) > XW'(PG)) ? GW'(PG) : GW'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfla_pkg::S_INIT;
            r_count <= CW'(1);
            r_free  <= FTW'(POOL_BYTES);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
        end
        r_i        <= n_i;
        r_k        <= n_k;
        r_best     <= n_best;
        r_op       <= n_op;
        r_need     <= n_need;
        r_g        <= n_g;
        r_n        <= n_n;
        r_have     <= n_have;
        r_bestg    <= n_bestg;
        r_bestbase <= n_bestbase;
        r_curbase  <= n_curbase;
        r_curg     <= n_curg;
        r_status   <= n_status;
        r_gaddr    <= n_gaddr;
        r_gsize    <= n_gsize;
    end

    always_comb begin
        logic          v_have;
        logic [GW-1:0] v_bestg;
        logic [BW-1:0] v_bestbase;
        logic [CW-1:0] v_best;
        logic [GW-1:0] v_newg;
        logic [XW-1:0] v_sum;
        logic [GW-1:0] v_sat;

        n_state    = r_state;
        n_i        = r_i;
        n_k        = r_k;
        n_count    = r_count;
        n_best     = r_best;
        n_free     = r_free;
        n_op       = r_op;
        n_need     = r_need;
        n_g        = r_g;
        n_n        = r_n;
        n_have     = r_have;
        n_bestg    = r_bestg;
        n_bestbase = r_bestbase;
        n_curbase  = r_curbase;
        n_curg     = r_curg;
        n_status   = r_status;
        n_gaddr    = r_gaddr;
        n_gsize    = r_gsize;
        ram_we     = 1'b0;
        ram_waddr  = r_i[IW-1:0];
        ram_wdata  = '0;
        ram_raddr  = r_i[IW-1:0];
        v_have     = r_have;
        v_bestg    = r_bestg;
        v_bestbase = r_bestbase;
        v_best     = r_best;
        v_newg     = '0;
        v_sum      = '0;
        v_sat      = '0;

        unique case (r_state)
            pfla_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {BW'(0), GW'(PG)};
                n_state   = pfla_pkg::S_IDLE;
            end
            pfla_pkg::S_IDLE: begin
                if (start) begin
                    n_op     = i_cmd.opcode;
                    n_status = pfla_pkg::ST_OK;
                    n_gaddr  = '0;
                    n_gsize  = '0;
                    n_i      = '0;
                    n_have   = 1'b0;
                    n_need   = NW'(req_sum >> LG);
                    n_g      = BW'(i_cmd.release_address >> LG);
                    n_n      = SW'(i_cmd.release_size >> LG);
                    priority if (i_cmd.opcode == pfla_pkg::OP_ALLOC) begin
                        if (r_count == '0) begin
                            n_status = pfla_pkg::ST_NOFIT;
                            n_state  = pfla_pkg::S_DONE;
                        end else begin
                            n_state  = pfla_pkg::S_AS_RD;
                        end
                    end else if (i_cmd.opcode == pfla_pkg::OP_FREE) begin
                        if (SW'(i_cmd.release_size >> LG) == '0) begin
                            n_state = pfla_pkg::S_DONE;
                        end else if (r_count == '0) begin
                            n_k     = '0;
                            n_state = pfla_pkg::S_IN_RD;
                        end else begin
                            n_state = pfla_pkg::S_FS_RD;
                        end
                    end else if (i_cmd.opcode == pfla_pkg::OP_DEFRAG) begin
                        n_state = (r_count == '0) ? pfla_pkg::S_DONE : pfla_pkg::S_DI_RD;
                    end else begin
                        n_state = pfla_pkg::S_DONE;
                    end
                end
            end
            pfla_pkg::S_AS_RD: begin
                n_state = pfla_pkg::S_AS_CMP;
            end
            pfla_pkg::S_AS_CMP: begin
                if (XW'(rd_gran) == XW'(r_need)) begin
                    n_gaddr = pfla_pkg::ADDR_W'(pfla_pkg::ADDR_W'(rd_base) << LG);
                    n_gsize = pfla_pkg::SIZE_W'(bytes);
                    n_free  = free_minus;
                    n_k     = r_i;
                    n_state = pfla_pkg::S_RM_RD;
                end else begin
                    if (XW'(rd_gran) > XW'(r_need) && (!r_have || rd_gran < r_bestg)) begin
                        v_have     = 1'b1;
                        v_bestg    = rd_gran;
                        v_bestbase = rd_base;
                        v_best     = r_i;
                    end
                    n_have     = v_have;
                    n_bestg    = v_bestg;
                    n_bestbase = v_bestbase;
                    n_best     = v_best;
                    n_i        = r_i + CW'(1);
                    if (r_i + CW'(1) == r_count) begin
                        if (!v_have) begin
                            n_status = pfla_pkg::ST_NOFIT;
                        end else begin
                            // carve from the tail of the best segment
                            v_newg    = GW'(XW'(v_bestg) - XW'(r_need));
                            ram_we    = 1'b1;
                            ram_waddr = v_best[IW-1:0];
                            ram_wdata = {v_bestbase, v_newg};
                            n_gaddr   = pfla_pkg::ADDR_W'(
                                            pfla_pkg::ADDR_W'(BW'(XW'(v_bestbase) + XW'(v_newg)))
                                            << LG);
                            n_gsize   = pfla_pkg::SIZE_W'(bytes);
                            n_free    = free_minus;
                        end
                        n_state = pfla_pkg::S_DONE;
                    end else begin
                        n_state = pfla_pkg::S_AS_RD;
                    end
                end
            end
            pfla_pkg::S_FS_RD: begin
                n_state = pfla_pkg::S_FS_CMP;
            end
            pfla_pkg::S_FS_CMP: begin
                if (XW'(rd_base) + XW'(rd_gran) == XW'(r_g)) begin
                    v_sum     = XW'(rd_gran) + XW'(r_n);
                    v_sat     = (v_sum > XW'(PG)) ? GW'(PG) : GW'(v_sum);
                    ram_we    = 1'b1;
                    ram_wdata = {rd_base, v_sat};
                    n_free    = free_plus;
                    n_state   = pfla_pkg::S_DONE;
                end else begin
                    n_i = r_i + CW'(1);
                    if (r_i + CW'(1) == r_count) begin
                        if (r_count >= CW'(MAX_SEGMENTS)) begin
                            n_status = pfla_pkg::ST_FULL;
                            n_state  = pfla_pkg::S_DONE;
                        end else begin
                            n_k     = r_count;
                            n_state = pfla_pkg::S_IN_RD;
                        end
                    end else begin
                        n_state = pfla_pkg::S_FS_RD;
                    end
                end
            end
            pfla_pkg::S_IN_RD: begin
                if (r_k == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = {r_g, n_clip};
                    n_count   = r_count + CW'(1);
                    n_free    = free_plus;
                    n_state   = pfla_pkg::S_DONE;
                end else begin
                    ram_raddr = IW'(r_k - CW'(1));
                    n_state   = pfla_pkg::S_IN_WR;
                end
            end
            pfla_pkg::S_IN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[IW-1:0];
                ram_wdata = ram_rdata;
                n_k       = r_k - CW'(1);
                n_state   = pfla_pkg::S_IN_RD;
            end
            pfla_pkg::S_RM_RD: begin
                if (r_k + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                    if (r_op == pfla_pkg::OP_DEFRAG) begin
                        n_i     = '0;
                        n_state = pfla_pkg::S_DI_RD;
                    end else begin
                        n_state = pfla_pkg::S_DONE;
                    end
                end else begin
                    ram_raddr = IW'(r_k + CW'(1));
                    n_state   = pfla_pkg::S_RM_WR;
                end
            end
            pfla_pkg::S_RM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[IW-1:0];
                ram_wdata = ram_rdata;
                n_k       = r_k + CW'(1);
                n_state   = pfla_pkg::S_RM_RD;
            end
            pfla_pkg::S_DI_RD: begin
                n_state = pfla_pkg::S_DI_GET;
            end
            pfla_pkg::S_DI_GET: begin
                n_curbase = rd_base;
                n_curg    = rd_gran;
                n_k       = '0;
                n_state   = pfla_pkg::S_DJ_RD;
            end
            pfla_pkg::S_DJ_RD: begin
                ram_raddr = r_k[IW-1:0];
                n_state   = pfla_pkg::S_DJ_CMP;
            end
            pfla_pkg::S_DJ_CMP: begin
                if (r_k != r_i && XW'(rd_base) == XW'(r_curbase) + XW'(r_curg)) begin
                    v_sum     = XW'(r_curg) + XW'(rd_gran);
                    v_sat     = (v_sum > XW'(PG)) ? GW'(PG) : GW'(v_sum);
                    ram_we    = 1'b1;
                    ram_waddr = r_i[IW-1:0];
                    ram_wdata = {r_curbase, v_sat};
                    n_state   = pfla_pkg::S_RM_RD;
                end else begin
                    n_k = r_k + CW'(1);
                    if (r_k + CW'(1) == r_count) begin
                        n_i     = r_i + CW'(1);
                        n_state = (r_i + CW'(1) == r_count) ? pfla_pkg::S_DONE
                                                            : pfla_pkg::S_DI_RD;
                    end else begin
                        n_state = pfla_pkg::S_DJ_RD;
                    end
                end
            end
            pfla_pkg::S_DONE: begin
                n_state = pfla_pkg::S_IDLE;
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != pfla_pkg::S_IDLE);
    assign o_done = (r_state == pfla_pkg::S_DONE);
    assign o_result.status        = r_status;
    assign o_result.grant_address = r_gaddr;
    assign o_result.grant_size    = r_gsize;
    assign o_result.free_bytes    = pfla_pkg::SIZE_W'(r_free);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count above table depth");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FTW'(POOL_BYTES))
        else $error("free total above pool size");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result beat not single cycle");

endmodule
